### design/gsh_pkg.sv
// gsh_pkg: shared types, field widths, command and status codes of the grid spatial hash
// no dependencies; compiled first
`timescale 1ns / 1ps

package gsh_pkg;

  localparam int ID_BITS     = 8;
  localparam int TAG_BITS    = 16;
  localparam int CFG_BITS    = 5;
  localparam int MAX_RESULTS = 64;
  localparam int HIT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_UPDATE  = 3'd1;
  localparam logic [2:0] CMD_REMOVE  = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_QRY_REG = 3'd4;
  localparam logic [2:0] CMD_QRY_ENT = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_FREE = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  localparam logic                CFG_IDX_GRID_W = 1'b0;
  localparam logic                CFG_IDX_GRID_H = 1'b1;
  localparam logic [CFG_BITS-1:0] CFG_RESET      = 5'd16;

  typedef struct packed {
    logic [2:0]          command;
    logic [ID_BITS-1:0]  entity_id;
    logic [9:0]          pos_x;
    logic [9:0]          pos_y;
    logic [9:0]          extent_w;
    logic [9:0]          extent_h;
    logic [TAG_BITS-1:0] user_tag;
  } in_beat_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  out_id;
    logic [TAG_BITS-1:0] out_tag;
    logic [2:0]          status;
    logic                last;
  } out_beat_t;

  // rectangle in cell units, x in the low nibble
  typedef struct packed {
    logic [3:0] ch;
    logic [3:0] cw;
    logic [3:0] cy;
    logic [3:0] cx;
  } rect_t;

  function automatic rect_t pack_rect(in_beat_t b);
    rect_t r;
    r.cx = b.pos_x[9:6];
    r.cy = b.pos_y[9:6];
    r.cw = b.extent_w[9:6];
    r.ch = b.extent_h[9:6];
    return r;
  endfunction

endpackage

### design/gsh_if.sv
// gsh_if: valid/ready channel interfaces for command beats and result beats
// depends on gsh_pkg
`timescale 1ns / 1ps

interface gsh_in_if;
  import gsh_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gsh_out_if;
  import gsh_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/grid_spatial_hash_engine.sv
// grid spatial hash: one command at a time, walked by a small sequencer over ram ports.
// add: allocates an id and writes its record. update/remove: scan the slots of each covered
// cell and shift the later ids down over the removed one. query: read each cell, up to 64 hits.
// clear zeroes the fill counts of all GRID_MAX_W*GRID_MAX_H cells in one sweep; the same sweep
// runs after reset and in_chan.ready stays low until it ends. config is taken any time.
`timescale 1ns / 1ps

module grid_spatial_hash_engine #(
  parameter int GRID_MAX_W   = 16,
  parameter int GRID_MAX_H   = 16,
  parameter int CELL_SLOTS   = 64,
  parameter int MAX_ENTITIES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gsh_in_if.sink                     in_chan,
  gsh_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [gsh_pkg::CFG_BITS-1:0] cfg_wdata
);
  import gsh_pkg::*;

  localparam int NUM_CELLS = GRID_MAX_W * GRID_MAX_H;
  localparam int CW  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int SL  = $clog2(CELL_SLOTS);
  localparam int SC  = SL + 1;
  localparam int FW  = $clog2(CELL_SLOTS + 1);
  localparam int SW  = $clog2(MAX_ENTITIES);
  localparam int SAW = CW + SL;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_ADD, S_ENT, S_ROW, S_COL, S_FILL, S_SLOT_RD, S_SLOT_CHK,
    S_SH_RD, S_SH_WR, S_Q_TAG, S_Q_PUSH, S_WDONE, S_RES, S_QEND
  } state_t;

  typedef enum logic [1:0] {M_DROP, M_PUT, M_QUERY} mode_t;

  function automatic logic [6:0] walk_lim(logic [3:0] o, logic [3:0] e, logic incl,
                                          logic [6:0] g);
    logic [6:0] endv;
    endv = 7'(o) + 7'(e) + 7'(incl);
    return (endv < g) ? endv : g;
  endfunction

  function automatic logic [SW-1:0] idx_of(logic [ID_BITS-1:0] v);
    logic [SW+ID_BITS-1:0] t;
    t = {{SW{1'b0}}, v};
    return t[SW-1:0];
  endfunction

  function automatic logic [ID_BITS-1:0] id_of(logic [SW-1:0] v);
    logic [SW+ID_BITS-1:0] t;
    t = {{ID_BITS{1'b0}}, v};
    return t[ID_BITS-1:0];
  endfunction

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [2:0]          cmd_r, cmd_nxt;
  logic [ID_BITS-1:0]  eid_r, eid_nxt;
  rect_t               rect_r, rect_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [TAG_BITS-1:0] ent_tag_r, ent_tag_nxt;
  logic [6:0]          x0_r, x0_nxt, xlim_r, xlim_nxt, ylim_r, ylim_nxt;
  logic [6:0]          px_r, px_nxt, py_r, py_nxt;
  logic [CW-1:0]       cell_r, cell_nxt;
  logic [SC-1:0]       n_r, n_nxt, i_r, i_nxt;
  logic                ok_r, ok_nxt, trunc_r, trunc_nxt;
  logic [HIT_W-1:0]    hits_r, hits_nxt;
  logic [ID_BITS-1:0]  pend_id_r, pend_id_nxt, nh_id_r, nh_id_nxt, res_id_r, res_id_nxt;
  logic [TAG_BITS-1:0] pend_tag_r, pend_tag_nxt, nh_tag_r, nh_tag_nxt;
  logic [2:0]          res_st_r, res_st_nxt;
  logic [SW:0]         top_r, top_nxt, lim_r, lim_nxt, top_m1;
  logic [CW-1:0]       sweep_r, sweep_nxt;
  logic                sweep_res_r, sweep_res_nxt;
  out_beat_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CFG_BITS-1:0] cfg_w_r, cfg_w_nxt, cfg_h_r, cfg_h_nxt;

  logic [6:0]  gw, gh;
  logic        out_free;
  logic [CW-1:0] cell_calc;
  logic [SW-1:0] add_id;

  // walk setup request
  logic  setup_en, setup_incl;
  rect_t setup_rect;
  mode_t setup_mode;

  // ram ports
  logic            f_we;
  logic [CW-1:0]   f_waddr, f_raddr;
  logic [FW-1:0]   f_wdata, f_rdata;
  logic            s_we;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [ID_BITS-1:0] s_wdata, s_rdata;
  logic            e_we;
  logic [SW-1:0]   e_waddr, e_raddr;
  logic [2*TAG_BITS-1:0] e_wdata, e_rdata;
  logic            k_we;
  logic [SW-1:0]   k_waddr, k_wdata, k_raddr, k_rdata;

  gsh_ram #(.WIDTH(FW), .DEPTH(2**CW)) u_fill (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );
  gsh_ram #(.WIDTH(ID_BITS), .DEPTH(2**SAW)) u_slots (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  gsh_ram #(.WIDTH(2*TAG_BITS), .DEPTH(MAX_ENTITIES)) u_ent (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );
  gsh_ram #(.WIDTH(SW), .DEPTH(MAX_ENTITIES)) u_stack (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata)
  );

  always_comb begin
    if (cfg_w_r == '0) gw = 7'd1;
    else if (7'(cfg_w_r) > 7'(GRID_MAX_W)) gw = 7'(GRID_MAX_W);
    else gw = 7'(cfg_w_r);
    if (cfg_h_r == '0) gh = 7'd1;
    else if (7'(cfg_h_r) > 7'(GRID_MAX_H)) gh = 7'(GRID_MAX_H);
    else gh = 7'(cfg_h_r);
  end

  assign out_free  = !out_valid_r || out_chan.ready;
  assign cell_calc = CW'(int'(py_r) * GRID_MAX_W + int'(px_r));
  assign top_m1    = top_r - 1'b1;
  // ids above the high-water mark were never pushed and still hold their own value
  assign add_id    = (top_r >= lim_r) ? top_r[SW-1:0] : k_rdata;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  always_comb begin
    state_nxt = state_r;   mode_nxt = mode_r;     cmd_nxt = cmd_r;
    eid_nxt = eid_r;       rect_nxt = rect_r;     tag_nxt = tag_r;
    ent_tag_nxt = ent_tag_r;
    x0_nxt = x0_r;         xlim_nxt = xlim_r;     ylim_nxt = ylim_r;
    px_nxt = px_r;         py_nxt = py_r;         cell_nxt = cell_r;
    n_nxt = n_r;           i_nxt = i_r;           ok_nxt = ok_r;
    trunc_nxt = trunc_r;   hits_nxt = hits_r;
    pend_id_nxt = pend_id_r; pend_tag_nxt = pend_tag_r;
    nh_id_nxt = nh_id_r;   nh_tag_nxt = nh_tag_r;
    res_id_nxt = res_id_r; res_st_nxt = res_st_r;
    top_nxt = top_r;       lim_nxt = lim_r;
    sweep_nxt = sweep_r;   sweep_res_nxt = sweep_res_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    cfg_w_nxt = cfg_w_r;   cfg_h_nxt = cfg_h_r;

    setup_en = 1'b0; setup_incl = 1'b0; setup_rect = rect_r; setup_mode = M_QUERY;

    f_we = 1'b0; f_waddr = cell_r; f_wdata = '0; f_raddr = cell_calc;
    s_we = 1'b0; s_waddr = {cell_r, i_r[SL-1:0]}; s_wdata = eid_r;
    s_raddr = {cell_r, i_r[SL-1:0]};
    e_we = 1'b0; e_waddr = idx_of(eid_r); e_wdata = {tag_r, rect_r};
    e_raddr = idx_of(in_chan.data.entity_id);
    k_we = 1'b0; k_waddr = top_m1[SW-1:0]; k_wdata = idx_of(eid_r);
    k_raddr = top_r[SW-1:0];

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_GRID_W: cfg_w_nxt = cfg_wdata;
        CFG_IDX_GRID_H: cfg_h_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_SWEEP: begin
        f_we    = 1'b1;
        f_waddr = sweep_r;
        if (sweep_r == CW'(NUM_CELLS - 1)) begin
          if (sweep_res_r) begin
            res_id_nxt = '0;
            res_st_nxt = ST_OK;
            state_nxt  = S_RES;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt  = in_chan.data.command;
          eid_nxt  = in_chan.data.entity_id;
          rect_nxt = pack_rect(in_chan.data);
          tag_nxt  = in_chan.data.user_tag;
          unique case (in_chan.data.command)
            CMD_ADD: begin
              if (top_r >= (SW+1)'(MAX_ENTITIES)) begin
                res_id_nxt = '0;
                res_st_nxt = ST_NO_FREE;
                state_nxt  = S_RES;
              end else begin
                state_nxt = S_ADD;
              end
            end
            CMD_UPDATE, CMD_REMOVE: begin
              if (int'(in_chan.data.entity_id) < MAX_ENTITIES) begin
                state_nxt = S_ENT;
              end else begin
                res_id_nxt = in_chan.data.entity_id;
                res_st_nxt = ST_OK;
                state_nxt  = S_RES;
              end
            end
            CMD_CLEAR: begin
              sweep_nxt     = '0;
              sweep_res_nxt = 1'b1;
              top_nxt       = '0;
              lim_nxt       = '0;
              state_nxt     = S_SWEEP;
            end
            CMD_QRY_REG: begin
              setup_en   = 1'b1;
              setup_rect = pack_rect(in_chan.data);
              setup_mode = M_QUERY;
            end
            CMD_QRY_ENT: begin
              if (int'(in_chan.data.entity_id) < MAX_ENTITIES) begin
                state_nxt = S_ENT;
              end else begin
                res_id_nxt = '0;
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_RES;
              end
            end
            default: ;
          endcase
        end
      end

      S_ADD: begin
        e_we    = 1'b1;
        e_waddr = add_id;
        top_nxt = top_r + 1'b1;
        if (top_r >= lim_r) lim_nxt = top_r + 1'b1;
        res_id_nxt = id_of(add_id);
        res_st_nxt = ST_OK;
        state_nxt  = S_RES;
      end

      S_ENT: begin
        ent_tag_nxt = e_rdata[2*TAG_BITS-1:TAG_BITS];
        setup_en    = 1'b1;
        setup_rect  = rect_t'(e_rdata[TAG_BITS-1:0]);
        if (cmd_r == CMD_QRY_ENT) begin
          setup_mode = M_QUERY;
        end else begin
          setup_mode = M_DROP;
          setup_incl = 1'b1;
        end
      end

      S_ROW: begin
        if (py_r >= ylim_r) begin
          state_nxt = S_WDONE;
        end else begin
          px_nxt    = x0_r;
          state_nxt = S_COL;
        end
      end

      S_COL: begin
        if (px_r >= xlim_r) begin
          py_nxt    = py_r + 7'd1;
          state_nxt = S_ROW;
        end else begin
          cell_nxt  = cell_calc;
          state_nxt = S_FILL;
        end
      end

      S_FILL: begin
        n_nxt = SC'(f_rdata);
        i_nxt = '0;
        if (mode_r == M_PUT) begin
          if (SC'(f_rdata) >= SC'(CELL_SLOTS)) begin
            ok_nxt = 1'b0;
          end else begin
            s_we    = 1'b1;
            s_waddr = {cell_r, SL'(f_rdata)};
            f_we    = 1'b1;
            f_wdata = FW'(SC'(f_rdata) + SC'(1));
          end
          px_nxt    = px_r + 7'd1;
          state_nxt = S_COL;
        end else begin
          state_nxt = S_SLOT_RD;
        end
      end

      S_SLOT_RD: begin
        if (i_r >= n_r) begin
          px_nxt    = px_r + 7'd1;
          state_nxt = S_COL;
        end else begin
          state_nxt = S_SLOT_CHK;
        end
      end

      S_SLOT_CHK: begin
        if (mode_r == M_DROP) begin
          if (s_rdata == eid_r) begin
            state_nxt = S_SH_RD;
          end else begin
            i_nxt     = i_r + SC'(1);
            state_nxt = S_SLOT_RD;
          end
        end else if (hits_r == HIT_W'(MAX_RESULTS)) begin
          trunc_nxt = 1'b1;
          state_nxt = S_QEND;
        end else begin
          e_raddr   = idx_of(s_rdata);
          nh_id_nxt = s_rdata;
          state_nxt = S_Q_TAG;
        end
      end

      // close the gap left by the removed id: S_SH_RD reads the next slot, S_SH_WR writes it one place down
      S_SH_RD: begin
        s_raddr = {cell_r, SL'(i_r + SC'(1))};
        if (i_r + SC'(1) >= n_r) begin
          f_we      = 1'b1;
          f_wdata   = FW'(n_r - SC'(1));
          px_nxt    = px_r + 7'd1;
          state_nxt = S_COL;
        end else begin
          state_nxt = S_SH_WR;
        end
      end

      S_SH_WR: begin
        s_we      = 1'b1;
        s_wdata   = s_rdata;
        i_nxt     = i_r + SC'(1);
        state_nxt = S_SH_RD;
      end

      S_Q_TAG: begin
        nh_tag_nxt = e_rdata[2*TAG_BITS-1:TAG_BITS];
        state_nxt  = S_Q_PUSH;
      end

      // one hit is held back so the final beat can carry last
      S_Q_PUSH: begin
        if (hits_r == '0 || out_free) begin
          if (hits_r != '0) begin
            out_nxt.out_id  = pend_id_r;
            out_nxt.out_tag = pend_tag_r;
            out_nxt.status  = ST_OK;
            out_nxt.last    = 1'b0;
            out_valid_nxt   = 1'b1;
          end
          pend_id_nxt  = nh_id_r;
          pend_tag_nxt = nh_tag_r;
          hits_nxt     = hits_r + 1'b1;
          i_nxt        = i_r + SC'(1);
          state_nxt    = S_SLOT_RD;
        end
      end

      S_WDONE: begin
        unique case (mode_r)
          M_QUERY: state_nxt = S_QEND;
          M_PUT: begin
            res_id_nxt = eid_r;
            res_st_nxt = ok_r ? ST_OK : ST_FULL;
            state_nxt  = S_RES;
          end
          M_DROP: begin
            if (cmd_r == CMD_UPDATE) begin
              e_we        = 1'b1;
              e_wdata     = {ent_tag_r, rect_r};
              setup_en    = 1'b1;
              setup_rect  = rect_r;
              setup_mode  = M_PUT;
              setup_incl  = 1'b1;
            end else begin
              if (top_r != '0) begin
                k_we    = 1'b1;
                top_nxt = top_m1;
              end
              res_id_nxt = eid_r;
              res_st_nxt = ST_OK;
              state_nxt  = S_RES;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_RES: begin
        if (out_free) begin
          out_nxt.out_id  = res_id_r;
          out_nxt.out_tag = '0;
          out_nxt.status  = res_st_r;
          out_nxt.last    = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      S_QEND: begin
        if (out_free) begin
          if (hits_r == '0) begin
            out_nxt.out_id  = '0;
            out_nxt.out_tag = '0;
            out_nxt.status  = ST_EMPTY;
          end else begin
            out_nxt.out_id  = pend_id_r;
            out_nxt.out_tag = pend_tag_r;
            out_nxt.status  = trunc_r ? ST_TRUNC : ST_OK;
          end
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (setup_en) begin
      mode_nxt  = setup_mode;
      x0_nxt    = 7'(setup_rect.cx);
      py_nxt    = 7'(setup_rect.cy);
      xlim_nxt  = walk_lim(setup_rect.cx, setup_rect.cw, setup_incl, gw);
      ylim_nxt  = walk_lim(setup_rect.cy, setup_rect.ch, setup_incl, gh);
      ok_nxt    = 1'b1;
      trunc_nxt = 1'b0;
      hits_nxt  = '0;
      state_nxt = S_ROW;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;       cmd_r <= cmd_nxt;       eid_r <= eid_nxt;
    rect_r <= rect_nxt;       tag_r <= tag_nxt;       ent_tag_r <= ent_tag_nxt;
    x0_r <= x0_nxt;           xlim_r <= xlim_nxt;     ylim_r <= ylim_nxt;
    px_r <= px_nxt;           py_r <= py_nxt;         cell_r <= cell_nxt;
    n_r <= n_nxt;             i_r <= i_nxt;           ok_r <= ok_nxt;
    trunc_r <= trunc_nxt;     hits_r <= hits_nxt;
    pend_id_r <= pend_id_nxt; pend_tag_r <= pend_tag_nxt;
    nh_id_r <= nh_id_nxt;     nh_tag_r <= nh_tag_nxt;
    res_id_r <= res_id_nxt;   res_st_r <= res_st_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      sweep_res_r <= 1'b0;
      top_r       <= '0;
      lim_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_w_r     <= CFG_RESET;
      cfg_h_r     <= CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      sweep_res_r <= sweep_res_nxt;
      top_r       <= top_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_w_r     <= cfg_w_nxt;
      cfg_h_r     <= cfg_h_nxt;
    end
  end

endmodule

### design/gsh_ram.sv
// gsh_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module gsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking bench for grid_spatial_hash_engine; a scoreboard class predicts
// every result beat; tasks drive commands and grid registers, a loop drives backpressure
// depends on gsh_pkg, gsh_if and the engine rtl
`timescale 1ns / 1ps

module tb_top;
  import gsh_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int         NUM_IDS     = 256;
  localparam int         SLOT_COUNT  = 64;
  localparam int         GRID_SIDE   = 16;
  localparam int         CYCLE_LIMIT = 60000000;

  class hash_board;
    logic [4:0]      grid_w_reg, grid_h_reg;
    int              fill[GRID_SIDE*GRID_SIDE];
    logic [7:0]      slots[GRID_SIDE*GRID_SIDE][SLOT_COUNT];
    rect_t           ent_rect[NUM_IDS];
    logic [15:0]     ent_tag[NUM_IDS];
    logic [7:0]      free_ids[NUM_IDS];
    int              free_top;
    out_beat_t       want_q[$];
    logic [7:0]      placed_ids[$];
    bit              placed[NUM_IDS];
    int              errors;

    function new();
      grid_w_reg = CFG_RESET;
      grid_h_reg = CFG_RESET;
      foreach (fill[c]) fill[c] = 0;
      foreach (placed[i]) placed[i] = 0;
      errors = 0;
      reset_alloc();
    endfunction

    function void reset_alloc();
      for (int i = 0; i < NUM_IDS; i++) free_ids[i] = i[7:0];
      free_top = 0;
    endfunction

    function void write_reg(logic idx, logic [4:0] val);
      if (idx == CFG_IDX_GRID_W) grid_w_reg = val;
      else grid_h_reg = val;
    endfunction

    function int clip(logic [4:0] v);
      if (v == 0) return 1;
      if (v > GRID_SIDE) return GRID_SIDE;
      return int'(v);
    endfunction

    function void push_want(logic [7:0] id, logic [15:0] tag, logic [2:0] st, logic lst);
      out_beat_t t;
      t.out_id = id;
      t.out_tag = tag;
      t.status = st;
      t.last = lst;
      want_q.push_back(t);
    endfunction

    function void drop_id(int c, logic [7:0] id);
      for (int i = 0; i < fill[c]; i++) begin
        if (slots[c][i] == id) begin
          for (int j = i; j + 1 < fill[c]; j++) slots[c][j] = slots[c][j+1];
          fill[c]--;
          return;
        end
      end
    endfunction

    // inclusive cover of the stored rectangle, clipped to the grid
    function bit walk_cover(logic [7:0] id, bit ins);
      rect_t r;
      int    x1, y1, w, h, c;
      bit    ok;
      r = ent_rect[id];
      x1 = r.cx + r.cw;
      y1 = r.cy + r.ch;
      w = clip(grid_w_reg);
      h = clip(grid_h_reg);
      ok = 1;
      for (int py = r.cy; py <= y1 && py < h; py++)
        for (int px = r.cx; px <= x1 && px < w; px++) begin
          c = px + py * GRID_SIDE;
          if (!ins) drop_id(c, id);
          else if (fill[c] >= SLOT_COUNT) ok = 0;
          else begin
            slots[c][fill[c]] = id;
            fill[c]++;
          end
        end
      return ok;
    endfunction

    // exclusive cover, stops after MAX_RESULTS beats
    function void query(rect_t r);
      int        n, w, h, c;
      bit        trunc;
      out_beat_t t;
      n = 0;
      trunc = 0;
      w = clip(grid_w_reg);
      h = clip(grid_h_reg);
      for (int py = r.cy; py < r.cy + r.ch && py < h && !trunc; py++)
        for (int px = r.cx; px < r.cx + r.cw && px < w && !trunc; px++) begin
          c = px + py * GRID_SIDE;
          for (int i = 0; i < fill[c]; i++) begin
            if (n == MAX_RESULTS) begin
              trunc = 1;
              break;
            end
            push_want(slots[c][i], ent_tag[slots[c][i]], ST_OK, 1'b0);
            n++;
          end
        end
      if (n == 0) begin
        push_want(8'd0, 16'd0, ST_EMPTY, 1'b1);
      end else begin
        t = want_q.pop_back();
        t.last = 1'b1;
        if (trunc) t.status = ST_TRUNC;
        want_q.push_back(t);
      end
    endfunction

    function void note_command(in_beat_t b);
      logic [7:0] id;
      bit         ok;
      case (b.command)
        CMD_ADD: begin
          if (free_top >= NUM_IDS) begin
            push_want(8'd0, 16'd0, ST_NO_FREE, 1'b1);
          end else begin
            id = free_ids[free_top];
            free_top++;
            ent_rect[id] = pack_rect(b);
            ent_tag[id] = b.user_tag;
            if (!placed[id]) begin
              placed[id] = 1;
              placed_ids.push_back(id);
            end
            push_want(id, 16'd0, ST_OK, 1'b1);
          end
        end
        CMD_UPDATE: begin
          ok = walk_cover(b.entity_id, 0);
          ent_rect[b.entity_id] = pack_rect(b);
          ok = walk_cover(b.entity_id, 1);
          push_want(b.entity_id, 16'd0, ok ? ST_OK : ST_FULL, 1'b1);
        end
        CMD_REMOVE: begin
          ok = walk_cover(b.entity_id, 0);
          if (free_top > 0) begin
            free_top--;
            free_ids[free_top] = b.entity_id;
          end
          push_want(b.entity_id, 16'd0, ST_OK, 1'b1);
        end
        CMD_CLEAR: begin
          foreach (fill[c]) fill[c] = 0;
          reset_alloc();
          push_want(8'd0, 16'd0, ST_OK, 1'b1);
        end
        CMD_QRY_REG: query(pack_rect(b));
        CMD_QRY_ENT: query(ent_rect[b.entity_id]);
        default: ;
      endcase
    endfunction

    function void check_result(out_beat_t r);
      out_beat_t w;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, r);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (r.out_id !== w.out_id) begin
        $display("%0t: out_id expected %0d actual %0d", $time, w.out_id, r.out_id);
        errors++;
      end
      if (r.out_tag !== w.out_tag) begin
        $display("%0t: out_tag expected %h actual %h", $time, w.out_tag, r.out_tag);
        errors++;
      end
      if (r.status !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, r.status);
        errors++;
      end
      if (r.last !== w.last) begin
        $display("%0t: last expected %0d actual %0d", $time, w.last, r.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [4:0] cfg_wdata;
  bit         quiet;
  bit         hold_req;
  hash_board  board;

  gsh_in_if  in_chan ();
  gsh_out_if out_chan ();

  grid_spatial_hash_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // result sink readiness: random stall bursts, one long hold-off on request
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_chan.valid && out_chan.ready) board.check_result(out_chan.data);

  task automatic send_beat(in_beat_t b);
    in_chan.data  <= b;
    in_chan.valid <= 1'b1;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    board.note_command(b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // stop offering, then wait for every expected result
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (board.want_q.size() != 0);
  endtask

  // idle point: all results in, then room for a command that gives none
  task automatic settle();
    drain();
    in_chan.valid <= 1'b0;
    repeat (300) @(posedge clk);
  endtask

  task automatic set_grid(logic [4:0] w, logic [4:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_GRID_W;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_IDX_GRID_H;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(CFG_IDX_GRID_W, w);
    board.write_reg(CFG_IDX_GRID_H, h);
  endtask

  function automatic in_beat_t make_beat(logic [2:0] cmd, logic [7:0] id, int x, int y,
                                         int w, int h, logic [15:0] tag);
    in_beat_t b;
    b.command = cmd;
    b.entity_id = id;
    b.pos_x = x[9:0];
    b.pos_y = y[9:0];
    b.extent_w = w[9:0];
    b.extent_h = h[9:0];
    b.user_tag = tag;
    return b;
  endfunction

  function automatic logic [7:0] pick_placed();
    return board.placed_ids[$urandom_range(0, board.placed_ids.size() - 1)];
  endfunction

  function automatic int rand_extent();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(0, 255) : $urandom_range(0, 1023);
  endfunction

  function automatic in_beat_t rand_command();
    int         roll;
    logic [2:0] cmd;
    roll = $urandom_range(0, 99);
    if (roll < 20) cmd = CMD_ADD;
    else if (roll < 50) cmd = CMD_UPDATE;
    else if (roll < 60) cmd = CMD_REMOVE;
    else if (roll < 63) cmd = CMD_CLEAR;
    else if (roll < 83) cmd = CMD_QRY_REG;
    else if (roll < 95) cmd = CMD_QRY_ENT;
    else cmd = roll[0] ? CMD_SPARE_7 : CMD_SPARE_6;
    // id-addressed commands only touch entities whose rectangle has been written
    if (board.placed_ids.size() == 0 &&
        (cmd == CMD_UPDATE || cmd == CMD_REMOVE || cmd == CMD_QRY_ENT))
      cmd = CMD_ADD;
    return make_beat(cmd, board.placed_ids.size() ? pick_placed() : 8'd0,
                     $urandom_range(0, 1023), $urandom_range(0, 1023),
                     rand_extent(), rand_extent(), 16'($urandom_range(0, 65535)));
  endfunction

  task automatic mixed_phase(int n_items, bit pressure);
    in_beat_t b;
    for (int k = 0; k < n_items; k++) begin
      b = rand_command();
      if (pressure && k == 4) hold_req = 1;
      if (pressure && k == 14) drain();
      send_beat(b);
    end
  endtask

  task automatic crowd_phase();
    logic [7:0] id;
    send_beat(make_beat(CMD_CLEAR, 8'd0, 0, 0, 0, 0, 16'd0));
    // after the clear the allocator hands out ids 0 to 71 in order
    for (int i = 0; i < 72; i++)
      send_beat(make_beat(CMD_ADD, 8'd0, $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          16'($urandom_range(0, 65535))));
    // pile distinct ids onto cell (2,2) until it overflows
    for (int i = 0; i < 72; i++) begin
      id = 8'(i);
      send_beat(make_beat(CMD_UPDATE, id, $urandom_range(128, 191), $urandom_range(128, 191),
                          $urandom_range(0, 127), $urandom_range(0, 127), 16'd0));
      if (i % 12 == 11)
        send_beat(make_beat(CMD_QRY_REG, 8'd0, $urandom_range(0, 191),
                            $urandom_range(0, 191), $urandom_range(64, 383),
                            $urandom_range(64, 383), 16'd0));
    end
    for (int i = 0; i < 12; i++) begin
      id = pick_placed();
      if (i % 3 == 0) send_beat(make_beat(CMD_QRY_ENT, id, 0, 0, 0, 0, 16'd0));
      else send_beat(make_beat(CMD_REMOVE, id, 0, 0, 0, 0, 16'd0));
    end
  endtask

  task automatic directed_phase();
    send_beat(make_beat(CMD_QRY_REG, 8'd0, 0, 0, 1023, 1023, 16'd0));
    send_beat(make_beat(CMD_ADD, 8'd0, 0, 0, 0, 0, 16'h0000));
    send_beat(make_beat(CMD_ADD, 8'd0, 1023, 1023, 1023, 1023, 16'hffff));
    send_beat(make_beat(CMD_UPDATE, 8'd0, 0, 0, 1023, 1023, 16'd0));
    send_beat(make_beat(CMD_UPDATE, 8'd1, 1023, 1023, 1023, 1023, 16'd0));
    send_beat(make_beat(CMD_QRY_REG, 8'd0, 0, 0, 1023, 1023, 16'd0));
    send_beat(make_beat(CMD_QRY_ENT, 8'd1, 0, 0, 0, 0, 16'd0));
    send_beat(make_beat(CMD_QRY_ENT, 8'd0, 0, 0, 0, 0, 16'd0));
    send_beat(make_beat(CMD_SPARE_6, 8'hff, 1023, 1023, 1023, 1023, 16'hffff));
    send_beat(make_beat(CMD_SPARE_7, 8'h00, 0, 0, 0, 0, 16'h0000));
    send_beat(make_beat(CMD_REMOVE, 8'd1, 0, 0, 0, 0, 16'd0));
    send_beat(make_beat(CMD_ADD, 8'd0, 64, 64, 63, 63, 16'h5a5a));
    send_beat(make_beat(CMD_REMOVE, 8'd0, 0, 0, 0, 0, 16'd0));
    send_beat(make_beat(CMD_CLEAR, 8'd0, 0, 0, 0, 0, 16'd0));
    // allocator already full after clear: the id is not pushed back
    send_beat(make_beat(CMD_REMOVE, 8'd0, 0, 0, 0, 0, 16'd0));
    send_beat(make_beat(CMD_QRY_REG, 8'd0, 0, 0, 1023, 1023, 16'd0));
  endtask

  initial begin
    board = new();
    quiet = 0;
    hold_req = 0;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_IDX_GRID_W;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    directed_phase();
    settle();
    crowd_phase();
    settle();
    set_grid(5'd1, 5'd1);
    mixed_phase(15, 1);
    settle();
    set_grid(5'd0, 5'd31);
    mixed_phase(15, 0);
    settle();
    set_grid(5'd31, 5'd0);
    mixed_phase(15, 0);
    settle();
    set_grid(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)));
    mixed_phase(15, 0);
    settle();
    set_grid(5'd16, 5'd16);
    mixed_phase(15, 0);
    settle();
    quiet = 1;
    set_grid(5'd5, 5'd9);
    mixed_phase(16, 0);

    drain();
    in_chan.valid <= 1'b0;
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.want_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### grid_spatial_hash_engine.f
design/gsh_pkg.sv
design/gsh_if.sv
design/gsh_ram.sv
design/grid_spatial_hash_engine.sv
tb/sv/tb_top.sv
